### design/stdp_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and table builders for the STDP weight update unit.
// No dependencies.
package stdp_pkg;

   localparam int LOG_TABLE_BITS_DEF = 8;
   localparam int LOG_W  = 16;   // log2 table entry, fractional Q.16
   localparam int EXP_W  = 31;   // exp2 table entry, Q1.30
   localparam int SCALE_W = 20;
   localparam int SHAPE_W = 16;
   localparam int WEIGHT_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [1:0] {
      MODE_CONSTANT     = 2'd0,
      MODE_LINEAR       = 2'd1,
      MODE_POWER_MIRROR = 2'd2,
      MODE_POWER        = 2'd3
   } scale_mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAUSAL_SCALE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANTICAUSAL_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAUSAL_SHAPE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANTICAUSAL_SHAPE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAUSAL_OFFSET     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ANTICAUSAL_OFFSET = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WEIGHT        = 3'd7;

   localparam logic [SCALE_W-1:0]  RST_CAUSAL_SCALE     = 20'd62259;
   localparam logic [SCALE_W-1:0]  RST_ANTICAUSAL_SCALE = 20'd2048;
   localparam logic [SHAPE_W-1:0]  RST_SHAPE            = 16'd0;
   localparam logic [SHAPE_W-1:0]  RST_OFFSET           = 16'd2048;
   localparam logic [WEIGHT_W-1:0] RST_MAX_WEIGHT       = 16'd32768;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_arg;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // log2(1 + i/2^bits), fraction bits only, by repeated squaring
   function automatic logic [LOG_W-1:0] log_entry(input int i, input int bits);
      logic [63:0] x;
      logic [LOG_W-1:0] y;
      x = (64'd1 << 30) + (64'(i) << (30 - bits));
      y = '0;
      for (int k = LOG_W - 1; k >= 0; k--) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            y[k] = 1'b1;
         end
      end
      return y;
   endfunction

   // 2^(i/2^bits) in Q1.30 as a product of 2^(2^-k) roots
   function automatic logic [EXP_W-1:0] exp_entry(input int i, input int bits);
      logic [63:0] root [0:12];
      logic [63:0] e;
      for (int k = 0; k <= 12; k++) root[k] = 64'd0;
      root[1] = isqrt64(64'd2 << 60);
      for (int k = 2; k <= 12; k++) begin
         if (k <= bits) root[k] = isqrt64(root[k-1] << 30);
      end
      e = 64'd1 << 30;
      for (int k = 0; k < 12; k++) begin
         if (k < bits && ((i >> k) & 1) == 1) e = (e * root[bits-k]) >> 30;
      end
      return EXP_W'(e);
   endfunction

endpackage

### design/stdp_rom.sv
`timescale 1ns / 1ps
// Constant log2 and exp2 lookup tables for the power scale modes.
// Depends on stdp_pkg.
module stdp_rom #(
   parameter int LOG_TABLE_BITS = stdp_pkg::LOG_TABLE_BITS_DEF
) (
   input  logic [LOG_TABLE_BITS-1:0]   log_idx,
   output logic [stdp_pkg::LOG_W-1:0]  log_data,
   input  logic [LOG_TABLE_BITS-1:0]   exp_idx,
   output logic [stdp_pkg::EXP_W-1:0]  exp_data
);
   import stdp_pkg::*;

   localparam int DEPTH = 1 << LOG_TABLE_BITS;

   logic [LOG_W-1:0] log_rom [DEPTH];
   logic [EXP_W-1:0] exp_rom [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      assign log_rom[g] = log_entry(g, LOG_TABLE_BITS);
      assign exp_rom[g] = exp_entry(g, LOG_TABLE_BITS);
   end

   assign log_data = log_rom[log_idx];
   assign exp_data = exp_rom[exp_idx];

endmodule

### design/stdp_weight_update_unit.sv
`timescale 1ns / 1ps
// Weight-dependent STDP update: new weight = w + trace * scale(w), clipped.
// Six register stages; rsp_valid is the valid bit of stage 6.
// Throughput one request per cycle while rsp_stall is low; each stage holds
// only while the one after it is full and held, so bubbles collapse under stall.
// Reset clears all stage valids and loads the register defaults.
// Depends on stdp_pkg and stdp_rom.
module stdp_weight_update_unit #(
   parameter int LOG_TABLE_BITS = stdp_pkg::LOG_TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [stdp_pkg::WEIGHT_W-1:0]       req_weight_in,
   input  logic [15:0]                         req_trace,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [stdp_pkg::WEIGHT_W-1:0]       rsp_weight_out,
   output logic                                rsp_clipped_high,
   output logic                                rsp_clipped_low,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stdp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stdp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import stdp_pkg::*;

   // ---------------- configuration registers ----------------
   scale_mode_type        mode_ff;
   logic [SCALE_W-1:0]    c_scale_ff, a_scale_ff;
   logic [SHAPE_W-1:0]    c_shape_ff, a_shape_ff, c_offs_ff, a_offs_ff;
   logic [WEIGHT_W-1:0]   max_weight_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CONSTANT;
         c_scale_ff    <= RST_CAUSAL_SCALE;
         a_scale_ff    <= RST_ANTICAUSAL_SCALE;
         c_shape_ff    <= RST_SHAPE;
         a_shape_ff    <= RST_SHAPE;
         c_offs_ff     <= RST_OFFSET;
         a_offs_ff     <= RST_OFFSET;
         max_weight_ff <= RST_MAX_WEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE_MODE:        mode_ff       <= scale_mode_type'(csr_data[1:0]);
            CSR_CAUSAL_SCALE:      c_scale_ff    <= csr_data;
            CSR_ANTICAUSAL_SCALE:  a_scale_ff    <= csr_data;
            CSR_CAUSAL_SHAPE:      c_shape_ff    <= csr_data[SHAPE_W-1:0];
            CSR_ANTICAUSAL_SHAPE:  a_shape_ff    <= csr_data[SHAPE_W-1:0];
            CSR_CAUSAL_OFFSET:     c_offs_ff     <= csr_data[SHAPE_W-1:0];
            CSR_ANTICAUSAL_OFFSET: a_offs_ff     <= csr_data[SHAPE_W-1:0];
            CSR_MAX_WEIGHT:        max_weight_ff <= csr_data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage flow control ----------------
   logic [6:1] v_ff;
   logic [6:1] ld;

   always_comb begin
      ld[6] = !v_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) ld[k] = !v_ff[k] || ld[k+1];
   end

   assign req_stall = !ld[1];
   assign rsp_valid = v_ff[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[1]) v_ff[1] <= req_valid;
         for (int k = 2; k <= 6; k++) begin
            if (ld[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // ---------------- table ROMs ----------------
   logic [LOG_TABLE_BITS-1:0] log_idx, exp_idx;
   logic [LOG_W-1:0]          log_data;
   logic [EXP_W-1:0]          exp_data;

   stdp_rom #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_rom (
      .log_idx  (log_idx),
      .log_data (log_data),
      .exp_idx  (exp_idx),
      .exp_data (exp_data)
   );

   // ---------------- stage 1: select, base, leading one, slope product ----------------
   scale_mode_type              s1_mode_ff;
   logic signed [SCALE_W-1:0]   s1_s_ff;
   logic signed [SHAPE_W-1:0]   s1_shape_ff, s1_offs_ff;
   logic [WEIGHT_W-1:0]         s1_w_ff, s1_t_ff, s1_maxw_ff;
   logic signed [32:0]          s1_prod_ff, s1_prod_in;
   logic [3:0]                  s1_e_ff, s1_e_in;
   logic [LOG_TABLE_BITS-1:0]   s1_idx_ff, s1_idx_in;
   logic                        s1_bzero_ff, s1_bzero_in;

   logic [WEIGHT_W-1:0] base;
   logic [14:0]         mant;
   logic signed [SHAPE_W-1:0] shape_sel;

   always_comb begin
      shape_sel = req_operation ? a_shape_ff : c_shape_ff;
      if (mode_ff == MODE_POWER_MIRROR && !req_operation) begin
         base = (req_weight_in >= 16'd32768) ? 16'd0 : 16'd32768 - req_weight_in;
      end else begin
         base = req_weight_in;
      end
      s1_e_in = 4'd0;
      for (int b = 0; b < WEIGHT_W; b++) begin
         if (base[b]) s1_e_in = 4'(b);
      end
      mant        = 15'(base << (4'd15 - s1_e_in));
      s1_idx_in   = mant[14 -: LOG_TABLE_BITS];
      s1_bzero_in = (base == '0);
      s1_prod_in  = shape_sel * $signed({1'b0, req_weight_in});
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_mode_ff  <= mode_ff;
         s1_s_ff     <= req_operation ? a_scale_ff : c_scale_ff;
         s1_shape_ff <= shape_sel;
         s1_offs_ff  <= req_operation ? a_offs_ff : c_offs_ff;
         s1_w_ff     <= req_weight_in;
         s1_t_ff     <= req_trace;
         s1_maxw_ff  <= max_weight_ff;
         s1_prod_ff  <= s1_prod_in;
         s1_e_ff     <= s1_e_in;
         s1_idx_ff   <= s1_idx_in;
         s1_bzero_ff <= s1_bzero_in;
      end
   end

   // ---------------- stage 2: log lookup, linear scale ----------------
   scale_mode_type              s2_mode_ff;
   logic signed [SCALE_W-1:0]   s2_s_ff;
   logic signed [SHAPE_W-1:0]   s2_shape_ff;
   logic [WEIGHT_W-1:0]         s2_w_ff, s2_t_ff, s2_maxw_ff;
   logic signed [21:0]          s2_lg_ff, s2_lg_in;
   logic signed [15:0]          s2_l_ff, s2_l_in;
   logic                        s2_bzero_ff;

   logic signed [5:0]  esub;
   logic signed [17:0] pshift;
   logic signed [18:0] lsum;

   assign log_idx = s1_idx_ff;

   always_comb begin
      esub     = $signed({2'b00, s1_e_ff}) - 6'sd15;
      s2_lg_in = $signed({esub, 16'h0000}) + $signed({6'b0, log_data});
      pshift   = 18'(s1_prod_ff >>> 15);
      lsum     = $signed({pshift[17], pshift}) + 19'(s1_offs_ff);
      if (lsum > 19'sd32767)       s2_l_in = 16'sh7FFF;
      else if (lsum < -19'sd32768) s2_l_in = 16'sh8000;
      else                         s2_l_in = lsum[15:0];
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_s_ff     <= s1_s_ff;
         s2_shape_ff <= s1_shape_ff;
         s2_w_ff     <= s1_w_ff;
         s2_t_ff     <= s1_t_ff;
         s2_maxw_ff  <= s1_maxw_ff;
         s2_lg_ff    <= s2_lg_in;
         s2_l_ff     <= s2_l_in;
         s2_bzero_ff <= s1_bzero_ff;
      end
   end

   // ---------------- stage 3: exponent times log ----------------
   scale_mode_type              s3_mode_ff;
   logic signed [SCALE_W-1:0]   s3_s_ff;
   logic [WEIGHT_W-1:0]         s3_w_ff, s3_t_ff, s3_maxw_ff;
   logic signed [24:0]          s3_z_ff;
   logic signed [15:0]          s3_l_ff;
   logic                        s3_bzero_ff, s3_mu_pos_ff, s3_mu_zero_ff;
   logic signed [37:0]          zprod;

   assign zprod = s2_lg_ff * s2_shape_ff;

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s3_mode_ff    <= s2_mode_ff;
         s3_s_ff       <= s2_s_ff;
         s3_w_ff       <= s2_w_ff;
         s3_t_ff       <= s2_t_ff;
         s3_maxw_ff    <= s2_maxw_ff;
         s3_z_ff       <= 25'(zprod >>> 13);
         s3_l_ff       <= s2_l_ff;
         s3_bzero_ff   <= s2_bzero_ff;
         s3_mu_pos_ff  <= !s2_shape_ff[15] && (s2_shape_ff != '0);
         s3_mu_zero_ff <= (s2_shape_ff == '0);
      end
   end

   // ---------------- stage 4: exp lookup and shift, pick multiplicand ----------------
   scale_mode_type              s4_mode_ff;
   logic signed [SCALE_W-1:0]   s4_s_ff;
   logic [WEIGHT_W-1:0]         s4_w_ff, s4_t_ff, s4_maxw_ff;
   logic signed [20:0]          s4_op_ff, s4_op_in;

   logic signed [8:0] n;
   logic [4:0]        sh;
   logic [EXP_W-1:0]  eshift;
   logic [19:0]       p;

   assign exp_idx = s3_z_ff[15 -: LOG_TABLE_BITS];

   always_comb begin
      n      = s3_z_ff[24:16];
      sh     = 5'(9'sd14 - n);
      eshift = exp_data >> sh;
      if (s3_bzero_ff) begin
         if (s3_mu_pos_ff)       p = 20'd0;
         else if (s3_mu_zero_ff) p = 20'd65536;
         else                    p = 20'hFFFFF;
      end else if (n >= 9'sd4) begin
         p = 20'hFFFFF;
      end else if (n <= -9'sd17) begin
         p = 20'd0;
      end else if (eshift > 31'h000FFFFF) begin
         p = 20'hFFFFF;
      end else begin
         p = eshift[19:0];
      end
      if (s3_mode_ff == MODE_LINEAR) s4_op_in = 21'(s3_l_ff);
      else                           s4_op_in = $signed({1'b0, p});
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         s4_mode_ff <= s3_mode_ff;
         s4_s_ff    <= s3_s_ff;
         s4_w_ff    <= s3_w_ff;
         s4_t_ff    <= s3_t_ff;
         s4_maxw_ff <= s3_maxw_ff;
         s4_op_ff   <= s4_op_in;
      end
   end

   // ---------------- stage 5: scale factor ----------------
   logic signed [SCALE_W-1:0]   s5_f_ff, s5_f_in;
   logic [WEIGHT_W-1:0]         s5_w_ff, s5_t_ff, s5_maxw_ff;
   logic signed [40:0]          fprod;
   logic signed [28:0]          fshift;

   always_comb begin
      fprod  = s4_s_ff * s4_op_ff;
      fshift = (s4_mode_ff == MODE_LINEAR) ? 29'(fprod >>> 12) : 29'(fprod >>> 16);
      if (s4_mode_ff == MODE_CONSTANT)  s5_f_in = s4_s_ff;
      else if (fshift > 29'sd524287)    s5_f_in = 20'sh7FFFF;
      else if (fshift < -29'sd524288)   s5_f_in = 20'sh80000;
      else                              s5_f_in = fshift[19:0];
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         s5_f_ff    <= s5_f_in;
         s5_w_ff    <= s4_w_ff;
         s5_t_ff    <= s4_t_ff;
         s5_maxw_ff <= s4_maxw_ff;
      end
   end

   // ---------------- stage 6: apply and clip ----------------
   logic [WEIGHT_W-1:0] s6_w_ff, s6_w_in;
   logic                s6_hi_ff, s6_hi_in, s6_lo_ff, s6_lo_in;
   logic signed [36:0]  dprod;
   logic signed [24:0]  sum;

   always_comb begin
      dprod = $signed({1'b0, s5_t_ff}) * s5_f_ff;
      sum   = $signed({9'b0, s5_w_ff}) + 25'(dprod >>> 13);
      s6_hi_in = 1'b0;
      s6_lo_in = 1'b0;
      if (sum > $signed({9'b0, s5_maxw_ff})) begin
         s6_w_in  = s5_maxw_ff;
         s6_hi_in = 1'b1;
      end else if (sum < 25'sd0) begin
         s6_w_in  = '0;
         s6_lo_in = 1'b1;
      end else begin
         s6_w_in = sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         s6_w_ff  <= s6_w_in;
         s6_hi_ff <= s6_hi_in;
         s6_lo_ff <= s6_lo_in;
      end
   end

   assign rsp_weight_out   = s6_w_ff;
   assign rsp_clipped_high = s6_hi_ff;
   assign rsp_clipped_low  = s6_lo_ff;

   // ---------------- checks ----------------
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_clipped_high && rsp_clipped_low))
      else $error("both clip flags set");

   a_low_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped_low |-> rsp_weight_out == '0)
      else $error("low clip with nonzero weight");

   a_high_clip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped_high |-> rsp_weight_out == s5_maxw_ff || v_ff[5] ||
      rsp_weight_out == max_weight_ff)
      else $error("high clip not at bound");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_ff == 6'b111111))
      else $error("request stalled with a free stage");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_out))
      else $error("held result lost");

endmodule

### sim/tb_stdp_weight_update_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for stdp_weight_update_unit: directed and random requests
// under random stalls, scored against a built-in fixed-point predictor.
// Depends on stdp_pkg and the design sources.
module tb_stdp_weight_update_unit;
   import stdp_pkg::*;

   localparam int TBL_BITS = LOG_TABLE_BITS_DEF;
   localparam int TBL_N    = 1 << TBL_BITS;

   typedef struct {
      logic [15:0] weight;
      logic        hi;
      logic        lo;
   } update_result_type;

   class weight_update_scoreboard;
      logic [19:0]          regs [8];
      longint unsigned      log_rom [TBL_N];
      longint unsigned      exp_rom [TBL_N];
      update_result_type    expected_q [$];
      int                   mismatches;

      function new();
         longint unsigned root [TBL_BITS+1];
         longint unsigned x, e;
         int unsigned y;
         mismatches = 0;
         regs[0] = 20'd0;
         regs[1] = 20'd62259;
         regs[2] = 20'd2048;
         regs[3] = 20'd0;
         regs[4] = 20'd0;
         regs[5] = 20'd2048;
         regs[6] = 20'd2048;
         regs[7] = 20'd32768;
         root[0] = 0;
         root[1] = sqrt_floor(64'd2 << 60);
         for (int k = 2; k <= TBL_BITS; k++) root[k] = sqrt_floor(root[k-1] << 30);
         for (int i = 0; i < TBL_N; i++) begin
            x = (64'd1 << 30) + (longint'(i) << (30 - TBL_BITS));
            y = 0;
            for (int k = 15; k >= 0; k--) begin
               x = (x * x) >> 30;
               if (x >= (64'd2 << 30)) begin
                  x = x >> 1;
                  y = y | (1 << k);
               end
            end
            log_rom[i] = y;
            e = 64'd1 << 30;
            for (int k = 0; k < TBL_BITS; k++)
               if ((i >> k) & 1) e = (e * root[TBL_BITS-k]) >> 30;
            exp_rom[i] = e;
         end
      endfunction

      function longint unsigned sqrt_floor(longint unsigned v_in);
         longint unsigned v, r, b;
         v = v_in;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void set_reg(logic [2:0] idx, logic [19:0] data);
         int width;
         width = (idx == CSR_SCALE_MODE) ? 2 :
                 (idx == CSR_CAUSAL_SCALE || idx == CSR_ANTICAUSAL_SCALE) ? 20 : 16;
         regs[idx] = 20'(data & ((20'd1 << width) - 1));
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // b^mu with b in Q1.15, mu in Q3.13, result in Q4.16
      function longint power_q16(longint b, longint mu);
         longint lg, z, n;
         int e;
         longint mant;
         int j;
         if (b <= 0) begin
            if (mu > 0) return 0;
            return (mu == 0) ? 65536 : 20'hFFFFF;
         end
         e = 15;
         while (((b >> e) & 1) == 0) e--;
         mant = (b << (15 - e)) & 16'h7FFF;
         lg = longint'(e - 15) * 65536 + longint'(log_rom[mant >> (15 - TBL_BITS)]);
         z = (lg * mu) >>> 13;
         n = z >>> 16;
         if (n >= 4) return 20'hFFFFF;
         if (n <= -17) return 0;
         j = int'(((z - n * 65536) >> (16 - TBL_BITS)) & (TBL_N - 1));
         return clip(longint'(exp_rom[j] >> (14 - n)), 0, 20'hFFFFF);
      endfunction

      function void note_request(logic op, logic [15:0] w_in, logic [15:0] t_in);
         update_result_type r;
         bit causal;
         longint w, t, s, shape, offs, maxw, f, l, base, sum;
         causal = (op == 1'b0);
         w = w_in;
         t = t_in;
         s = $signed(regs[causal ? CSR_CAUSAL_SCALE : CSR_ANTICAUSAL_SCALE]);
         shape = $signed(regs[causal ? CSR_CAUSAL_SHAPE : CSR_ANTICAUSAL_SHAPE][15:0]);
         offs = $signed(regs[causal ? CSR_CAUSAL_OFFSET : CSR_ANTICAUSAL_OFFSET][15:0]);
         maxw = regs[CSR_MAX_WEIGHT][15:0];
         case (scale_mode_type'(regs[CSR_SCALE_MODE][1:0]))
            MODE_CONSTANT: f = s;
            MODE_LINEAR: begin
               l = clip(((shape * w) >>> 15) + offs, -32768, 32767);
               f = clip((s * l) >>> 12, -524288, 524287);
            end
            default: begin
               base = (regs[CSR_SCALE_MODE][1:0] == MODE_POWER_MIRROR && causal) ?
                      clip(32768 - w, 0, 32768) : w;
               f = clip((s * power_q16(base, shape)) >>> 16, -524288, 524287);
            end
         endcase
         sum = w + ((t * f) >>> 13);
         r.hi = 0;
         r.lo = 0;
         if (sum > maxw) begin
            sum = maxw;
            r.hi = 1;
         end else if (sum < 0) begin
            sum = 0;
            r.lo = 1;
         end
         r.weight = sum[15:0];
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [15:0] w, logic hi, logic lo);
         update_result_type r;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response weight=%h", w);
            return;
         end
         r = expected_q.pop_front();
         if (w !== r.weight || hi !== r.hi || lo !== r.lo) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected w=%h hi=%b lo=%b, got w=%h hi=%b lo=%b",
                        r.weight, r.hi, r.lo, w, hi, lo);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset;
   logic        req_valid, req_stall, req_operation;
   logic [15:0] req_weight_in, req_trace;
   logic        rsp_valid, rsp_clipped_high, rsp_clipped_low;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_weight_out;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [19:0] csr_data;

   weight_update_scoreboard sb = new();
   int tx_idle = 13;
   int rx_idle = 72;
   bit hold_start = 0;
   int hold_left = 0;

   stdp_weight_update_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_weight_in(req_weight_in), .req_trace(req_trace),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_weight_out(rsp_weight_out),
      .rsp_clipped_high(rsp_clipped_high), .rsp_clipped_low(rsp_clipped_low),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = 80;
         hold_start = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_weight_out, rsp_clipped_high, rsp_clipped_low);
   end

   task automatic send_update(logic op, logic [15:0] w, logic [15:0] t);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_weight_in <= w;
      req_trace <= t;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, w, t);
   endtask

   // csr_valid stays high across back-to-back writes; caller lowers it
   task automatic write_reg(logic [2:0] idx, logic [19:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [19:0] rand_signed(int max_bits);
      int k;
      logic [19:0] v;
      k = $urandom_range(max_bits, 2);
      v = 20'($urandom_range((1 << k) - 1, 0));
      if ($urandom_range(1)) v = -v;
      return v;
   endfunction

   task automatic configure(int phase, int mode);
      logic [19:0] junk;
      junk = 20'({$urandom_range(15, 0), 16'h0});
      write_reg(CSR_SCALE_MODE, 20'({$urandom_range(262143, 0), 2'b00} | mode));
      for (int i = 1; i <= 6; i++) begin
         if (phase == 5)
            write_reg(i[2:0], (i <= 2) ? 20'h7FFFF : (junk | 20'h7FFF));
         else if (phase == 9)
            write_reg(i[2:0], (i <= 2) ? 20'h80000 : (junk | 20'h8000));
         else if (i <= 2)
            write_reg(i[2:0], rand_signed(19));
         else if (i <= 4 && mode >= MODE_POWER_MIRROR)
            // keep most exponents moderate so powers stay in range
            write_reg(i[2:0], junk | (($urandom_range(3) == 0) ? rand_signed(15)
                                                               : rand_signed(14)));
         else
            write_reg(i[2:0], junk | rand_signed(15));
      end
      write_reg(CSR_MAX_WEIGHT, (phase == 9) ? 20'h0 : (phase == 5 || phase == 10) ?
                (junk | 20'hFFFF) : (junk | 20'($urandom_range(65535, 16384))));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed();
      logic [15:0] w_list [7] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001,
                                  16'h4000, 16'hC000};
      // reset values: extremes of the fields, weight above bound with zero trace
      send_update(1'b0, 16'hFFFF, 16'h0000);
      send_update(1'b1, 16'h0000, 16'hFFFF);
      send_update(1'b0, 16'h7FFF, 16'hFFFF);
      send_update(1'b1, 16'hFFFF, 16'hFFFF);
      drain();
      // mirrored power: weights past the mirror point, zero base with exponent above zero, then power at exponent zero
      write_reg(CSR_SCALE_MODE, 20'(MODE_POWER_MIRROR));
      write_reg(CSR_CAUSAL_SHAPE, 20'h02000);
      write_reg(CSR_ANTICAUSAL_SHAPE, 20'h0E000);
      csr_valid <= 1'b0;
      @(posedge clock);
      foreach (w_list[i]) send_update(i[0], w_list[i], 16'h1000);
      drain();
      write_reg(CSR_CAUSAL_SHAPE, 20'h0);
      write_reg(CSR_SCALE_MODE, 20'(MODE_POWER));
      csr_valid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 4; i++) send_update(i[0], w_list[i], 16'h0800);
      drain();
      write_reg(CSR_SCALE_MODE, 20'(MODE_LINEAR));
      csr_valid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 4; i++) send_update(i[1], w_list[i], 16'hFFFF);
      drain();
   endtask

   initial begin
      logic [15:0] w, t;
      logic [15:0] maxw;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= 1'b0;
      req_weight_in <= '0;
      req_trace <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 4) begin
            tx_idle = 72;
            rx_idle = 13;
         end else if (phase == 8) begin
            tx_idle = 0;
            rx_idle = 0;
         end
         configure(phase, phase % 4);
         maxw = sb.regs[CSR_MAX_WEIGHT][15:0];
         if (phase == 2) hold_start = 1;
         for (int n = 0; n < 115; n++) begin
            case ($urandom_range(3))
               0: w = 16'($urandom);
               default: w = 16'($urandom_range(maxw, 0));
            endcase
            t = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4095, 0));
            send_update(1'($urandom_range(1)), w, t);
         end
         drain();
      end
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
